// ===== sv/dip_pkg.sv =====
// Shared types and constants for the decimal int64 parser.
// No dependencies; the stage, scan and top-level files import this package.
package dip_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [63:0] POS_MAG_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2
  } dip_status_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       span_end;
  } dip_item_t;

  typedef struct packed {
    logic signed [63:0] parsed_value;
    logic [1:0]         parse_status;
  } dip_result_t;

endpackage

// ===== sv/dip_if.sv =====
// Valid/ready channel interfaces for the parser's byte input and result output.
// Standalone; used by the top level and the pipeline stages.
interface dip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       span_end;

  modport source(output valid, output text_byte, output has_byte, output span_end,
                 input ready);
  modport sink(input valid, input text_byte, input has_byte, input span_end,
               output ready);
endinterface

interface dip_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] parsed_value;
  logic [1:0]         parse_status;

  modport source(output valid, output parsed_value, output parse_status, input ready);
  modport sink(input valid, input parsed_value, input parse_status, output ready);
endinterface

// ===== sv/dip_in_stage.sv =====
// Input register for one byte beat.
// Depends on dip_pkg and dip_in_if.
module dip_in_stage
  import dip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dip_in_if.sink    in_i,
  input  logic      advance_i,
  output logic      valid_o,
  output dip_item_t item_o
);

  logic      valid_q;
  dip_item_t item_q;
  logic      take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{text_byte: in_i.text_byte, has_byte: in_i.has_byte,
                  span_end: in_i.span_end};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/dip_scan.sv =====
// Scan state machine and decimal accumulator; one byte per cycle while fire_i is high.
// Depends on dip_pkg.
module dip_scan
  import dip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  dip_item_t   item_i,
  output dip_result_t result_o
);

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_STOP} phase_e;

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [63:0] mag_q, mag_d;
  logic        ovf_q, ovf_d;
  logic        seen_q, seen_d;

  logic        is_space;
  logic        is_digit;
  logic        is_sign;
  logic [3:0]  digit;
  logic [63:0] cap;
  logic [67:0] next_mag;
  logic        take_digit;
  dip_status_e status;

  assign is_space = (item_i.text_byte == CHAR_SPACE) || (item_i.text_byte == CHAR_TAB) ||
                    (item_i.text_byte == CHAR_LF) || (item_i.text_byte == CHAR_CR) ||
                    (item_i.text_byte == CHAR_VT) || (item_i.text_byte == CHAR_FF);
  assign is_digit = (item_i.text_byte >= CHAR_ZERO) && (item_i.text_byte <= CHAR_NINE);
  assign is_sign  = (item_i.text_byte == CHAR_PLUS) || (item_i.text_byte == CHAR_MINUS);
  assign digit    = item_i.text_byte[3:0];
  assign cap      = neg_q ? INT64_MIN_MAG : POS_MAG_CAP;

  // mag*10 + d at full width; anything past 64 bits is also past the cap
  assign next_mag = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {64'd0, digit};

  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    ovf_d      = ovf_q;
    seen_d     = seen_q;
    take_digit = 1'b0;

    if (item_i.has_byte) begin
      unique case (phase_q) inside
        PH_SKIP: begin
          if (is_space) begin
            phase_d = PH_SKIP;
          end else if (is_sign) begin
            neg_d   = (item_i.text_byte == CHAR_MINUS);
            phase_d = PH_SIGN;
          end else if (is_digit) begin
            take_digit = 1'b1;
            phase_d    = PH_DIGITS;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            take_digit = 1'b1;
            phase_d    = PH_DIGITS;
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: ;
      endcase
    end

    if (take_digit) begin
      seen_d = 1'b1;
      if (!ovf_q) begin
        if (next_mag > {4'd0, cap}) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = next_mag[63:0];
        end
      end
    end

    if (!seen_d) begin
      status = ST_NO_DIGITS;
    end else if (ovf_d) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end

    result_o.parse_status = status;
    result_o.parsed_value = (status == ST_OK) ? (neg_d ? -mag_d : mag_d) : 64'sd0;

    if (item_i.span_end) begin
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      mag_d   = '0;
      ovf_d   = 1'b0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
    end
  end

  // magnitude stays within the cap of the current sign
  a_mag_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !neg_q |-> (mag_q <= POS_MAG_CAP))
    else $error("magnitude above positive cap");

  a_mag_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= INT64_MIN_MAG)
    else $error("magnitude above negative cap");

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (mag_q == 64'd0 && !ovf_q))
    else $error("magnitude or overflow without digits");

  a_span_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.span_end) |=> (phase_q == PH_SKIP && !neg_q && !seen_q && !ovf_q))
    else $error("state not cleared after span end");

endmodule

// ===== sv/dip_out_stage.sv =====
// Result register driving the output channel.
// Depends on dip_pkg and dip_out_if.
module dip_out_stage
  import dip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  dip_result_t result_i,
  output logic        free_o,
  dip_out_if.source   out_o
);

  logic        valid_q;
  dip_result_t result_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.parsed_value = result_q.parsed_value;
  assign out_o.parse_status = result_q.parse_status;

endmodule

// ===== sv/decimal_int64_parser.sv =====
// Decimal text to int64 parser: one text byte per beat, one result per span.
// A span's result is formed combinationally and loaded into the result register.
// One byte per cycle unless a span-end beat waits; mag*10+d and cap check are combinational.
// A stalled output holds one result; bytes keep flowing until the next span-end beat,
// which then waits in the input register. Asynchronous active-low reset empties both
// registers and returns the scanner to whitespace skipping with a zero magnitude.
module decimal_int64_parser
  import dip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dip_in_if.sink    in_i,
  dip_out_if.source out_o
);

  logic        s1_valid;
  dip_item_t   s1_item;
  logic        out_free;
  logic        fire;
  dip_result_t result;

  // an end-of-span beat needs room in the result register
  assign fire = s1_valid && (!s1_item.span_end || out_free);

  dip_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (fire),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  dip_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .result_o (result)
  );

  dip_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && s1_item.span_end),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule
